// ===== sv/i2cmrts_pkg.sv =====
// Shared types and constants for the I2C master register transfer sequencer.
// Used by the step logic, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package i2cmrts_pkg;

  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int POS_W      = 4;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [BYTE_W-1:0] WORD_ADDR_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0] DEV_ADDR_MASK  = 8'hFE;
  localparam logic [BYTE_W-1:0] AUTO_INC_RESET = 8'h80;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN      = 3'd0,
    CMD_LOAD       = 3'd1,
    CMD_START_SENT = 3'd2,
    CMD_BYTE_SENT  = 3'd3,
    CMD_BYTE_RCVD  = 3'd4,
    CMD_OTHER      = 3'd5
  } command_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_SEND  = 3'd1,
    ACT_START = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_RESET = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_WRITING = 2'd1,
    ST_READING = 2'd2
  } xfer_status_t;

  typedef enum logic {
    REG_AUTO_INC = 1'b0,
    REG_ACK_POLL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] device_address;
    logic [BYTE_W-1:0] word_address;
    logic [LEN_W-1:0]  length;
    logic              read_flag;
    logic [BYTE_W-1:0] write_byte;
    logic [POS_W-1:0]  write_index;
    logic              ack_seen;
    logic [BYTE_W-1:0] rx_data;
  } item_t;

  typedef struct packed {
    action_t           bus_action;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_out;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic [POS_W-1:0]  rx_index;
    logic              busy_res;
    xfer_status_t      status_code;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] target_address;
    logic              direction_read;
    logic              word_address_pending;
    logic              random_read_mode;
    logic              restart_pending;
    logic [BYTE_W-1:0] stored_word_address;
    logic [LEN_W-1:0]  transfer_length;
    logic [LEN_W-1:0]  byte_count;
    logic              busy_flag;
    xfer_status_t      transfer_status;
  } seq_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] auto_inc_flag;
    logic              ack_poll_en;
  } seq_cfg_t;

endpackage

// ===== sv/i2cmrts_wstore.sv =====
// Write data store: one write port, one read port with registered read data.
// A write to the address being read is forwarded. Depends on nothing.
`timescale 1ns / 1ps

module i2cmrts_wstore #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/i2cmrts_step.sv =====
// Next-state and result logic for one controller event of the sequencer.
// Depends on i2cmrts_pkg; the write store byte at the current count comes in ready.
`timescale 1ns / 1ps

module i2cmrts_step #(
  parameter int BUFFER_DEPTH = 16
) (
  input  i2cmrts_pkg::seq_cfg_t              cfg,
  input  i2cmrts_pkg::seq_state_t            state_r,
  input  i2cmrts_pkg::item_t                 item,
  input  logic [i2cmrts_pkg::BYTE_W-1:0]     store_byte,
  output i2cmrts_pkg::seq_state_t            state_nxt,
  output i2cmrts_pkg::result_t               result,
  output logic                               store_we
);

  always_comb begin
    state_nxt = state_r;
    result    = '0;
    result.bus_action = i2cmrts_pkg::ACT_NONE;
    store_we  = 1'b0;

    case (item.command)
      i2cmrts_pkg::CMD_BEGIN: begin
        state_nxt.target_address       = item.device_address;
        state_nxt.direction_read       = 1'b0;
        state_nxt.word_address_pending = 1'b1;
        state_nxt.random_read_mode     = item.read_flag;
        state_nxt.restart_pending      = 1'b0;
        state_nxt.stored_word_address  = (item.word_address & i2cmrts_pkg::WORD_ADDR_MASK)
            | ((item.length > i2cmrts_pkg::LEN_W'(1)) ? cfg.auto_inc_flag : '0);
        state_nxt.transfer_length = (int'(item.length) > BUFFER_DEPTH)
            ? i2cmrts_pkg::LEN_W'(BUFFER_DEPTH) : item.length;
        state_nxt.byte_count      = '0;
        state_nxt.busy_flag       = 1'b1;
        state_nxt.transfer_status = item.read_flag ? i2cmrts_pkg::ST_READING
                                                   : i2cmrts_pkg::ST_WRITING;
        result.bus_action = i2cmrts_pkg::ACT_START;
      end
      i2cmrts_pkg::CMD_LOAD: begin
        store_we = (int'(item.write_index) < BUFFER_DEPTH);
      end
      i2cmrts_pkg::CMD_START_SENT: begin
        result.tx_byte = (state_r.target_address & i2cmrts_pkg::DEV_ADDR_MASK)
            | i2cmrts_pkg::BYTE_W'(state_r.direction_read);
        state_nxt.byte_count = '0;
        result.bus_action = i2cmrts_pkg::ACT_SEND;
      end
      i2cmrts_pkg::CMD_BYTE_SENT: begin
        if (item.ack_seen) begin
          if (state_r.restart_pending) begin
            state_nxt.restart_pending = 1'b0;
            result.bus_action = i2cmrts_pkg::ACT_START;
          end else if (state_r.word_address_pending) begin
            state_nxt.word_address_pending = 1'b0;
            result.tx_byte    = state_r.stored_word_address;
            result.bus_action = i2cmrts_pkg::ACT_SEND;
            if (state_r.random_read_mode) begin
              // Word address goes out as a write; the data phase turns around
              // after a repeated start.
              state_nxt.restart_pending = 1'b1;
              state_nxt.direction_read  = 1'b1;
            end
          end else if (!state_r.direction_read) begin
            if ((state_r.byte_count < state_r.transfer_length)
                && (int'(state_r.byte_count) < BUFFER_DEPTH)) begin
              result.tx_byte       = store_byte;
              state_nxt.byte_count = state_r.byte_count + i2cmrts_pkg::LEN_W'(1);
              result.bus_action    = i2cmrts_pkg::ACT_SEND;
            end else begin
              result.bus_action         = i2cmrts_pkg::ACT_STOP;
              state_nxt.busy_flag       = 1'b0;
              state_nxt.transfer_status = i2cmrts_pkg::ST_FREE;
            end
          end
        end else if (cfg.ack_poll_en) begin
          result.bus_action = i2cmrts_pkg::ACT_START;
        end else begin
          result.bus_action         = i2cmrts_pkg::ACT_RESET;
          state_nxt.busy_flag       = 1'b0;
          state_nxt.transfer_status = i2cmrts_pkg::ST_FREE;
        end
      end
      i2cmrts_pkg::CMD_BYTE_RCVD: begin
        if (state_r.byte_count < state_r.transfer_length) begin
          result.rx_valid      = 1'b1;
          result.rx_byte       = item.rx_data;
          result.rx_index      = state_r.byte_count[i2cmrts_pkg::POS_W-1:0];
          state_nxt.byte_count = state_r.byte_count + i2cmrts_pkg::LEN_W'(1);
          result.ack_out       = 1'b1;
        end
        if (state_nxt.byte_count == state_r.transfer_length) begin
          result.ack_out            = 1'b0;
          result.bus_action         = i2cmrts_pkg::ACT_STOP;
          state_nxt.busy_flag       = 1'b0;
          state_nxt.transfer_status = i2cmrts_pkg::ST_FREE;
        end
      end
      default: begin
        result.bus_action         = i2cmrts_pkg::ACT_RESET;
        state_nxt.busy_flag       = 1'b0;
        state_nxt.transfer_status = i2cmrts_pkg::ST_FREE;
      end
    endcase

    result.busy_res    = state_nxt.busy_flag;
    result.status_code = state_nxt.transfer_status;
  end

endmodule

// ===== sv/i2c_master_register_transfer_sequencer.sv =====
// I2C master register transfer sequencer, top level: request and result stages,
// sequencer state, configuration registers. Depends on i2cmrts_pkg,
// i2cmrts_wstore and i2cmrts_step.
// An accepted request waits in the input register until the result register is free or
// being emptied, and its result then shows on out_tvalid from the result register.
// Throughput: one request per cycle while the result side keeps taking; the step logic
// and the write store's single write port handle one event per cycle. Reset (synchronous,
// rst_n low) empties both stages, clears the sequencer to free and restores the
// auto-increment flag to 0x80 and acknowledge polling to on. Write store contents are
// undefined until loaded.
`timescale 1ns / 1ps

module i2c_master_register_transfer_sequencer #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request channel. tdata, from bit 0 up: command[2:0], device_address[10:3],
  // word_address[18:11], length[23:19], read_flag[24], write_byte[32:25],
  // write_index[36:33], ack_seen[37], rx_data[45:38], zero fill[47:46].
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [i2cmrts_pkg::IN_DATA_W-1:0]    in_tdata,
  // Result channel. tdata, from bit 0 up: bus_action[2:0], tx_byte[10:3],
  // ack_out[11], rx_valid[12], rx_byte[20:13], rx_index[24:21], busy_res[25],
  // status_code[27:26], zero fill[31:28].
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [i2cmrts_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration writes: index 0 auto-increment flag, index 1 ack polling enable.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [i2cmrts_pkg::BYTE_W-1:0]       cfg_data
);

  // Store address width, and widths wide enough to carry the 4-bit write
  // position and the 5-bit byte count before trimming to the store address.
  localparam int ADDR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int WPOS_EW = (ADDR_W > i2cmrts_pkg::POS_W) ? ADDR_W : i2cmrts_pkg::POS_W;
  localparam int CNT_EW  = (ADDR_W > i2cmrts_pkg::LEN_W) ? ADDR_W : i2cmrts_pkg::LEN_W;

  logic                    in_valid_r;
  i2cmrts_pkg::item_t      in_item_r;
  i2cmrts_pkg::item_t      in_item;
  logic                    out_valid_r;
  i2cmrts_pkg::result_t    out_result_r;
  i2cmrts_pkg::seq_state_t state_r;
  i2cmrts_pkg::seq_state_t state_nxt;
  i2cmrts_pkg::seq_state_t state_step;
  i2cmrts_pkg::seq_cfg_t   cfg_r;
  i2cmrts_pkg::result_t    step_result;
  logic                    step_fire;
  logic                    store_we;
  logic [i2cmrts_pkg::BYTE_W-1:0] store_byte;
  logic [WPOS_EW-1:0]      wr_pos_ext;
  logic [CNT_EW-1:0]       rd_cnt_ext;

  // Unpack the request fields from tdata.
  assign in_item.command        = in_tdata[2:0];
  assign in_item.device_address = in_tdata[10:3];
  assign in_item.word_address   = in_tdata[18:11];
  assign in_item.length         = in_tdata[23:19];
  assign in_item.read_flag      = in_tdata[24];
  assign in_item.write_byte     = in_tdata[32:25];
  assign in_item.write_index    = in_tdata[36:33];
  assign in_item.ack_seen       = in_tdata[37];
  assign in_item.rx_data        = in_tdata[45:38];

  // The held request is processed when the result register is free or being
  // emptied this cycle. The input register accepts a new request whenever it
  // is empty or its request moves on, so it can take one more request while a
  // finished result waits downstream.
  assign step_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item;
    end
  end

  i2cmrts_step #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_step (
    .cfg        (cfg_r),
    .state_r    (state_r),
    .item       (in_item_r),
    .store_byte (store_byte),
    .state_nxt  (state_step),
    .result     (step_result),
    .store_we   (store_we)
  );

  // Sequencer state only moves when a request is processed.
  assign state_nxt = step_fire ? state_step : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The store is read ahead at the next byte count, so the byte
  // for the current count is always waiting in the store's read register.
  assign wr_pos_ext = WPOS_EW'(in_item_r.write_index);
  assign rd_cnt_ext = CNT_EW'(state_nxt.byte_count);

  i2cmrts_wstore #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (i2cmrts_pkg::BYTE_W)
  ) u_wstore (
    .clk     (clk),
    .wr_en   (step_fire && store_we),
    .wr_addr (wr_pos_ext[ADDR_W-1:0]),
    .wr_data (in_item_r.write_byte),
    .rd_addr (rd_cnt_ext[ADDR_W-1:0]),
    .rd_data (store_byte)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_result_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       out_result_r.status_code,
                       out_result_r.busy_res,
                       out_result_r.rx_index,
                       out_result_r.rx_byte,
                       out_result_r.rx_valid,
                       out_result_r.ack_out,
                       out_result_r.tx_byte,
                       out_result_r.bus_action};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_inc_flag <= i2cmrts_pkg::AUTO_INC_RESET;
      cfg_r.ack_poll_en   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cmrts_pkg::REG_AUTO_INC: cfg_r.auto_inc_flag <= cfg_data;
        i2cmrts_pkg::REG_ACK_POLL: cfg_r.ack_poll_en   <= cfg_data[0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A held request is never dropped while the result side stalls.
  a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |=> in_valid_r)
    else $error("request dropped while result stalled");

  // The busy flag and the transfer status agree in every result.
  a_busy_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_result_r.busy_res ==
                    (out_result_r.status_code != i2cmrts_pkg::ST_FREE)))
    else $error("busy flag disagrees with transfer status");

  // A delivered read byte comes with no action or with the closing stop.
  a_rx_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_result_r.rx_valid) |->
      (out_result_r.bus_action == i2cmrts_pkg::ACT_NONE ||
       out_result_r.bus_action == i2cmrts_pkg::ACT_STOP))
    else $error("read byte delivered with a bus action other than none or stop");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");
`endif

endmodule

// ===== tb/i2cmrts_sequence_checker.sv =====
// Checker for the I2C master register transfer sequencer: tracks configuration and requests,
// predicts every bus action and compares each result field by field.
// Depends on i2cmrts_pkg.
`timescale 1ns / 1ps

module i2cmrts_sequence_checker #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [i2cmrts_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [i2cmrts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [i2cmrts_pkg::BYTE_W-1:0]     cfg_data,
  output int                                 mismatch_count,
  output int                                 actions_outstanding,
  output int                                 actions_checked,
  output int                                 bytes_delivered
);
  import i2cmrts_pkg::*;

  seq_state_t        seq;
  seq_cfg_t          cfg;
  logic [BYTE_W-1:0] write_store [BUFFER_DEPTH];
  result_t           expected_actions [$];

  function automatic item_t unpack_request(input logic [IN_DATA_W-1:0] d);
    item_t r;
    r.command        = d[2:0];
    r.device_address = d[10:3];
    r.word_address   = d[18:11];
    r.length         = d[23:19];
    r.read_flag      = d[24];
    r.write_byte     = d[32:25];
    r.write_index    = d[36:33];
    r.ack_seen       = d[37];
    r.rx_data        = d[45:38];
    return r;
  endfunction

  function automatic result_t unpack_result(input logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.bus_action  = action_t'(d[2:0]);
    r.tx_byte     = d[10:3];
    r.ack_out     = d[11];
    r.rx_valid    = d[12];
    r.rx_byte     = d[20:13];
    r.rx_index    = d[24:21];
    r.busy_res    = d[25];
    r.status_code = xfer_status_t'(d[27:26]);
    return r;
  endfunction

  task automatic release_bus();
    seq.busy_flag       = 1'b0;
    seq.transfer_status = ST_FREE;
  endtask

  // Applies one controller event to the tracked sequencer state and returns the bus action.
  task automatic advance_sequencer(input item_t req, output result_t res);
    res = '0;
    case (req.command)
      CMD_BEGIN: begin
        seq.target_address       = req.device_address;
        seq.direction_read       = 1'b0;
        seq.word_address_pending = 1'b1;
        seq.random_read_mode     = req.read_flag;
        seq.restart_pending      = 1'b0;
        // The auto-increment decision looks at the raw length, before saturation.
        seq.stored_word_address  = (req.word_address & WORD_ADDR_MASK) |
                                   ((req.length > 1) ? cfg.auto_inc_flag : 8'h00);
        seq.transfer_length      = (int'(req.length) > BUFFER_DEPTH) ?
                                   LEN_W'(BUFFER_DEPTH) : req.length;
        seq.byte_count           = '0;
        seq.busy_flag            = 1'b1;
        seq.transfer_status      = req.read_flag ? ST_READING : ST_WRITING;
        res.bus_action           = ACT_START;
      end
      CMD_LOAD: begin
        if (int'(req.write_index) < BUFFER_DEPTH) write_store[req.write_index] = req.write_byte;
      end
      CMD_START_SENT: begin
        res.tx_byte    = (seq.target_address & DEV_ADDR_MASK) | {7'b0, seq.direction_read};
        seq.byte_count = '0;
        res.bus_action = ACT_SEND;
      end
      CMD_BYTE_SENT: begin
        if (req.ack_seen) begin
          if (seq.restart_pending) begin
            seq.restart_pending = 1'b0;
            res.bus_action      = ACT_START;
          end else if (seq.word_address_pending) begin
            seq.word_address_pending = 1'b0;
            res.tx_byte              = seq.stored_word_address;
            res.bus_action           = ACT_SEND;
            if (seq.random_read_mode) begin
              seq.restart_pending = 1'b1;
              seq.direction_read  = 1'b1;
            end
          end else if (!seq.direction_read) begin
            if (seq.byte_count < seq.transfer_length && int'(seq.byte_count) < BUFFER_DEPTH) begin
              res.tx_byte    = write_store[seq.byte_count[POS_W-1:0]];
              seq.byte_count = seq.byte_count + 1'b1;
              res.bus_action = ACT_SEND;
            end else begin
              res.bus_action = ACT_STOP;
              release_bus();
            end
          end
        end else if (cfg.ack_poll_en) begin
          res.bus_action = ACT_START;
        end else begin
          res.bus_action = ACT_RESET;
          release_bus();
        end
      end
      CMD_BYTE_RCVD: begin
        if (seq.byte_count < seq.transfer_length) begin
          res.rx_valid   = 1'b1;
          res.rx_byte    = req.rx_data;
          res.rx_index   = seq.byte_count[POS_W-1:0];
          seq.byte_count = seq.byte_count + 1'b1;
          res.ack_out    = 1'b1;
        end
        if (seq.byte_count == seq.transfer_length) begin
          res.ack_out    = 1'b0;
          res.bus_action = ACT_STOP;
          release_bus();
        end
      end
      default: begin
        res.bus_action = ACT_RESET;
        release_bus();
      end
    endcase
    res.busy_res    = seq.busy_flag;
    res.status_code = seq.transfer_status;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (!rst_n) begin
      seq                 = '0;
      cfg.auto_inc_flag   = AUTO_INC_RESET;
      cfg.ack_poll_en     = 1'b1;
      expected_actions.delete();
      foreach (write_store[i]) write_store[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_AUTO_INC) cfg.auto_inc_flag = cfg_data;
        else cfg.ack_poll_en = cfg_data[0];
      end
      if (out_tvalid && out_tready) begin
        got = unpack_result(out_tdata);
        actions_checked++;
        if (got.rx_valid) bytes_delivered++;
        if (expected_actions.size() == 0) begin
          $error("result 0x%0h arrived with no request waiting for it", out_tdata);
          mismatch_count++;
        end else begin
          want = expected_actions.pop_front();
          check_field("bus_action", want.bus_action, got.bus_action);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("ack_out", want.ack_out, got.ack_out);
          check_field("rx_valid", want.rx_valid, got.rx_valid);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("rx_index", want.rx_index, got.rx_index);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("status_code", want.status_code, got.status_code);
        end
      end
      if (in_tvalid && in_tready) begin
        advance_sequencer(unpack_request(in_tdata), want);
        expected_actions.push_back(want);
      end
    end
    actions_outstanding <= expected_actions.size();
  end

endmodule

// ===== tb/i2c_master_register_transfer_sequencer_tb.sv =====
// Top level of the sequencer testbench: clock, reset, request and configuration stimulus,
// result-side back-pressure and the final verdict. Depends on i2cmrts_pkg, the sequencer
// and i2cmrts_sequence_checker.
`timescale 1ns / 1ps

module i2c_master_register_transfer_sequencer_tb;
  import i2cmrts_pkg::*;

  localparam int BUFFER_DEPTH    = 16;
  localparam int TARGET_REQUESTS = 1150;
  localparam int CFG_PHASES      = 4;
  localparam int MAX_GAP         = 4;
  // Worst case is far below this, the drains included.
  localparam int CYCLE_LIMIT     = 200000;
  // Highest encoding the command field can carry; everything above CMD_OTHER is unknown status.
  localparam logic [CMD_W-1:0] CMD_HIGHEST = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index  = REG_AUTO_INC;
  logic [BYTE_W-1:0]     cfg_data   = '0;

  int mismatch_count;
  int actions_outstanding;
  int actions_checked;
  int bytes_delivered;

  int requests_sent = 0;
  int writes_run    = 0;
  int reads_run     = 0;
  int cfg_writes    = 0;
  int cycle_count   = 0;
  // When set, the request side sends back to back with no idle cycles.
  logic in_no_gaps  = 1'b0;

  i2c_master_register_transfer_sequencer #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  i2cmrts_sequence_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .actions_outstanding (actions_outstanding),
    .actions_checked     (actions_checked),
    .bytes_delivered     (bytes_delivered)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run stopped after %0d cycles, %0d results still outstanding",
             cycle_count, actions_outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Lays the request fields out on tdata, command in the lowest bits.
  function automatic logic [IN_DATA_W-1:0] pack_request(input item_t req);
    logic [IN_DATA_W-1:0] d;
    d        = '0;
    d[2:0]   = req.command;
    d[10:3]  = req.device_address;
    d[18:11] = req.word_address;
    d[23:19] = req.length;
    d[24]    = req.read_flag;
    d[32:25] = req.write_byte;
    d[36:33] = req.write_index;
    d[37]    = req.ack_seen;
    d[45:38] = req.rx_data;
    return d;
  endfunction

  // Every field is random, so the bits a command ignores still toggle; only the command is set.
  function automatic item_t random_request(input logic [CMD_W-1:0] cmd);
    logic [63:0] raw;
    item_t       req;
    raw         = {$urandom(), $urandom()};
    req         = raw[$bits(item_t)-1:0];
    req.command = cmd;
    return req;
  endfunction

  // Waits a random number of idle cycles, then offers the request until it is taken. The valid
  // stays high on return so that a back-to-back request never drops it for a cycle.
  task automatic send_request(input item_t req);
    int gap;
    gap = in_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_request(req);
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // A byte-sent event that the slave acknowledges. Now and then the slave first refuses it;
  // with polling on the sequencer then asks for a new start, which the controller reports.
  task automatic byte_sent_event();
    item_t req;
    req = random_request(CMD_BYTE_SENT);
    if ($urandom_range(0, 19) == 0) begin
      req.ack_seen = 1'b0;
      send_request(req);
      send_request(random_request(CMD_START_SENT));
    end
    req.ack_seen = 1'b1;
    send_request(req);
  endtask

  // One complete register transfer as a bus controller would report it. A write walks the
  // address, the word address, every data byte and the closing acknowledge that draws the stop.
  // A read walks the address, the word address, the repeated start, the read address and then
  // one received byte per data byte; a length-zero read still gets one byte, which ends it.
  task automatic run_transfer(input logic read, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] dev, input logic [BYTE_W-1:0] word);
    item_t req;
    int    data_events;
    req                = random_request(CMD_BEGIN);
    req.device_address = dev;
    req.word_address   = word;
    req.length         = len;
    req.read_flag      = read;
    send_request(req);
    send_request(random_request(CMD_START_SENT));
    byte_sent_event();
    byte_sent_event();
    data_events = (int'(len) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(len);
    if (read) begin
      byte_sent_event();
      send_request(random_request(CMD_START_SENT));
      byte_sent_event();
      repeat ((data_events == 0) ? 1 : data_events) send_request(random_request(CMD_BYTE_RCVD));
      reads_run++;
    end else begin
      repeat (data_events + 1) byte_sent_event();
      writes_run++;
    end
  endtask

  // Lets every outstanding result come back so that the block is idle.
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (actions_outstanding != 0);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [BYTE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Result side: a fresh random stall, possibly none, before each result, with stretches of full
  // throughput every so often so that the pipeline also runs without back-pressure.
  initial begin : result_sink
    int   stall;
    int   taken;
    logic no_stalls;
    taken     = 0;
    no_stalls = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 32 == 0) no_stalls = ($urandom_range(0, 3) == 0);
      stall = no_stalls ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    item_t            req;
    int               phase;
    int               pick;
    logic [LEN_W-1:0] len;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole write store first, so no write transfer ever fetches an entry that was
    // never loaded. The first and last entries carry the all-zeros and all-ones patterns.
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      req             = random_request(CMD_LOAD);
      req.write_index = POS_W'(i);
      if (i == 0) req.write_byte = 8'h00;
      if (i == BUFFER_DEPTH - 1) req.write_byte = 8'hFF;
      send_request(req);
    end

    // A received byte while idle finds nothing left: stop, no delivery.
    send_request(random_request(CMD_BYTE_RCVD));
    // Length-zero write and read with the address extremes: no auto-increment bit, the write
    // stops right after the word address and the read stops on its first byte undelivered.
    run_transfer(1'b0, '0, 8'hFF, 8'hFF);
    run_transfer(1'b1, '0, 8'h00, 8'h00);

    // A read longer than the store saturates its count but still sets the auto-increment bit.
    // The refused byte after the repeated start draws a new start from acknowledge polling.
    req                = random_request(CMD_BEGIN);
    req.device_address = 8'hA5;
    req.word_address   = 8'h80;
    req.length         = 5'd31;
    req.read_flag      = 1'b1;
    send_request(req);
    send_request(random_request(CMD_START_SENT));
    req          = random_request(CMD_BYTE_SENT);
    req.ack_seen = 1'b1;
    send_request(req);
    send_request(req);
    req.ack_seen = 1'b0;
    send_request(req);
    send_request(random_request(CMD_START_SENT));
    req.ack_seen = 1'b1;
    send_request(req);
    // A new begin while that read is still busy replaces it.
    req           = random_request(CMD_BEGIN);
    req.length    = 5'd1;
    req.read_flag = 1'b0;
    send_request(req);
    // Unknown status, both the named code and the top encoding, resets the interface.
    send_request(random_request(CMD_OTHER));
    send_request(random_request(CMD_HIGHEST));

    // Random part in four configuration phases: reset values, then both extremes, then random.
    for (phase = 0; phase < CFG_PHASES; phase++) begin
      if (phase > 0) begin
        drain_requests();
        case (phase)
          1: begin
            write_register(REG_AUTO_INC, 8'h00);
            write_register(REG_ACK_POLL, 8'hFE);
          end
          2: begin
            write_register(REG_AUTO_INC, 8'hFF);
            write_register(REG_ACK_POLL, 8'h01);
          end
          default: begin
            write_register(REG_AUTO_INC, BYTE_W'($urandom()));
            write_register(REG_ACK_POLL, BYTE_W'($urandom()));
          end
        endcase
      end
      while (requests_sent < (TARGET_REQUESTS * (phase + 1)) / CFG_PHASES) begin
        // Mostly complete transfers with random content; the rest is loads and stray events.
        in_no_gaps = ($urandom_range(0, 4) == 0);
        pick       = $urandom_range(0, 99);
        len        = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(17, 31))
                                                 : LEN_W'($urandom_range(0, 16));
        if (pick < 42) begin
          run_transfer(1'b0, len, BYTE_W'($urandom()), BYTE_W'($urandom()));
        end else if (pick < 84) begin
          run_transfer(1'b1, len, BYTE_W'($urandom()), BYTE_W'($urandom()));
        end else if (pick < 92) begin
          send_request(random_request(CMD_LOAD));
        end else begin
          repeat ($urandom_range(1, 4))
            send_request(random_request(CMD_W'($urandom_range(CMD_BEGIN, CMD_HIGHEST))));
        end
      end
    end

    drain_requests();
    // Waiting on after the drain catches any stray result.
    repeat (8) @(posedge clk);
    if (actions_outstanding != 0)
      $error("%0d expected results never arrived", actions_outstanding);

    $display("Covered %0d requests: %0d write and %0d read transfers among loads and stray events.",
             requests_sent, writes_run, reads_run);
    $display("Compared %0d results (%0d read bytes delivered) under %0d register writes.",
             actions_checked, bytes_delivered, cfg_writes);
    if (mismatch_count == 0 && actions_outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
